### rtl/lattice_height_neighbor_count_macros.svh
// ----------------------------------------------------------------------------
// Lattice height neighbor count: assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef LATTICE_HEIGHT_NEIGHBOR_COUNT_MACROS_SVH
`define LATTICE_HEIGHT_NEIGHBOR_COUNT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LHNC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lhnc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LHNC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lhnc assertion failed");

`endif

### rtl/lhnc_pkg.sv
// ----------------------------------------------------------------------------
// lhnc_pkg
// Field widths, packing sizes and register indexes of the lattice block.
// ----------------------------------------------------------------------------
package lhnc_pkg;

    localparam int POS_BITS        = 6;
    localparam int DELTA_BITS      = 8;
    localparam int SIZE_BITS       = 7;
    localparam int OUT_HEIGHT_BITS = 16;
    localparam int COUNT_BITS      = 3;

    localparam int S_TDATA_BITS = 24;
    localparam int M_TDATA_BITS = 32;
    localparam int M_TUSER_BITS = 1;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 7;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t CFG_LENGTH_IN_USE = 1'b0;
    localparam cfg_index_t CFG_WIDTH_IN_USE  = 1'b1;

    typedef logic [SIZE_BITS-1:0]  coord_t;
    typedef logic [COUNT_BITS-1:0] count_t;

endpackage

### rtl/lhnc_height_ram.sv
// ----------------------------------------------------------------------------
// lhnc_height_ram
// Height store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module lhnc_height_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr_a,
    input  logic [ADDR_BITS-1:0] raddr_b,
    output logic [DATA_BITS-1:0] rdata_a,
    output logic [DATA_BITS-1:0] rdata_b
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/lattice_height_neighbor_count.sv
// ----------------------------------------------------------------------------
// lattice_height_neighbor_count
// Periodic 2-D lattice of column heights with per-site neighbor counts.
// ----------------------------------------------------------------------------
// Input stream s_*: one transfer per site update (pos_x, pos_y, delta).
// Result stream m_*: one transfer per update: saturated new height and the
// fresh counts of the site and its four wrap-around neighbors; m_tuser flags
// a site outside the lattice size in use (then data is zero, nothing changes).
// Config port: cfg_we/cfg_index/cfg_wdata set the x and y periods; idle only.
// An in-range update passes the PREP, READ and DONE states before its result
// is loaded; an out-of-range one skips READ. The 13 heights around the site
// are fetched from the height RAM over its two read ports, two per cycle;
// the new center height is written back while the rest are still in flight.
// One update is in work at a time, so no new input is taken until the last
// one's result is loaded; the next input is taken while the result register
// still waits on m_tready. A stalled receiver holds the finished result and
// also holds the next update in DONE, which then blocks new input.
// Reset: a clearing pass writes zero heights to all 2**(XW+YW) RAM entries
// (4096 at the default sizes), one entry per cycle; s_tready stays low until
// it ends. Counts are derived from heights on every update.
// ----------------------------------------------------------------------------
module lattice_height_neighbor_count
    import lhnc_pkg::*;
#(
    parameter int MAX_LENGTH  = 64,
    parameter int MAX_WIDTH   = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [5:0] pos_x, [11:6] pos_y, [19:12] delta, [23:20] zero
    input  logic [S_TDATA_BITS-1:0]   s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [15:0] new_height, [18:16] count_here, [21:19] count_left,
    // [24:22] count_right, [27:25] count_below, [30:28] count_above, [31] zero
    output logic [M_TDATA_BITS-1:0]   m_tdata,
    // [0] bad_site
    output logic [M_TUSER_BITS-1:0]   m_tuser,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int SIZE_MAX = (1 << SIZE_BITS) - 1;
    localparam int LEN_CAP  = (MAX_LENGTH < SIZE_MAX) ? MAX_LENGTH : SIZE_MAX;
    localparam int WID_CAP  = (MAX_WIDTH < SIZE_MAX) ? MAX_WIDTH : SIZE_MAX;
    localparam int XW       = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;
    localparam int YW       = (WID_CAP > 1) ? $clog2(WID_CAP) : 1;
    localparam int AW       = XW + YW;
    localparam int LEN_RST  = (LEN_CAP < 64) ? LEN_CAP : 64;
    localparam int WID_RST  = (WID_CAP < 64) ? WID_CAP : 64;
    localparam int SLOTS    = 13;
    localparam int QLEN     = 14;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [2:0] STEP_WRITE = 3'd1;
    localparam logic [2:0] STEP_LAST  = 3'd7;

    // slot order of the fetched heights
    localparam int H_C  = 0;
    localparam int H_L  = 1;
    localparam int H_R  = 2;
    localparam int H_B  = 3;
    localparam int H_A  = 4;
    localparam int H_LL = 5;
    localparam int H_RR = 6;
    localparam int H_BB = 7;
    localparam int H_AA = 8;
    localparam int H_LB = 9;
    localparam int H_LA = 10;
    localparam int H_RB = 11;
    localparam int H_RA = 12;

    typedef logic signed [HEIGHT_BITS-1:0] height_t;

    function automatic coord_t wrap_dec(input coord_t c, input coord_t n);
        return (c == '0) ? coord_t'(n - 1'b1) : coord_t'(c - 1'b1);
    endfunction

    function automatic coord_t wrap_inc(input coord_t c, input coord_t n);
        return (c == coord_t'(n - 1'b1)) ? '0 : coord_t'(c + 1'b1);
    endfunction

    function automatic coord_t clamp_size(input logic [CFG_DATA_BITS-1:0] v,
                                          input coord_t cap);
        coord_t r;
        r = coord_t'(v);
        if (r == '0) begin
            r = coord_t'(1);
        end else if (r > cap) begin
            r = cap;
        end
        return r;
    endfunction

    function automatic count_t count_of(input height_t h0, input height_t n0,
                                        input height_t n1, input height_t n2,
                                        input height_t n3);
        count_t c;
        c = count_t'(1);
        c = c + count_t'(n0 >= h0);
        c = c + count_t'(n1 >= h0);
        c = c + count_t'(n2 >= h0);
        c = c + count_t'(n3 >= h0);
        return c;
    endfunction

    logic [2:0]                state_reg, state_next;
    logic [2:0]                step_reg;
    logic [AW-1:0]             clr_addr_reg;
    coord_t                    len_reg, wid_reg;
    coord_t                    x_reg, y_reg;
    logic signed [DELTA_BITS-1:0] d_reg;
    logic                      bad_reg;
    logic [AW-1:0]             ctr_addr_reg;
    coord_t                    q_x_reg [QLEN];
    coord_t                    q_y_reg [QLEN];
    logic [SLOTS-1:0]          eq_reg;
    height_t                   h_line_reg [QLEN];
    height_t                   hnew_reg;
    logic                      m_tvalid_reg;
    logic [M_TDATA_BITS-1:0]   m_tdata_reg;
    logic [M_TUSER_BITS-1:0]   m_tuser_reg;

    coord_t                    prep_x [QLEN];
    coord_t                    prep_y [QLEN];
    coord_t                    xl, xr, yb, ya;
    logic                      prep_bad;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [HEIGHT_BITS-1:0]    ram_wdata;
    logic [HEIGHT_BITS-1:0]    rd_a, rd_b;
    logic signed [HEIGHT_BITS:0] hsum;
    height_t                   hnew;
    height_t                   h_eff [SLOTS];
    count_t                    c_here, c_left, c_right, c_below, c_above;
    logic signed [31:0]        h_wide;
    logic                      out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // neighbor coordinates of the registered site
    always_comb begin
        xl = wrap_dec(x_reg, len_reg);
        xr = wrap_inc(x_reg, len_reg);
        yb = wrap_dec(y_reg, wid_reg);
        ya = wrap_inc(y_reg, wid_reg);
        prep_x[H_C]  = x_reg;                  prep_y[H_C]  = y_reg;
        prep_x[H_L]  = xl;                     prep_y[H_L]  = y_reg;
        prep_x[H_R]  = xr;                     prep_y[H_R]  = y_reg;
        prep_x[H_B]  = x_reg;                  prep_y[H_B]  = yb;
        prep_x[H_A]  = x_reg;                  prep_y[H_A]  = ya;
        prep_x[H_LL] = wrap_dec(xl, len_reg);  prep_y[H_LL] = y_reg;
        prep_x[H_RR] = wrap_inc(xr, len_reg);  prep_y[H_RR] = y_reg;
        prep_x[H_BB] = x_reg;                  prep_y[H_BB] = wrap_dec(yb, wid_reg);
        prep_x[H_AA] = x_reg;                  prep_y[H_AA] = wrap_inc(ya, wid_reg);
        prep_x[H_LB] = xl;                     prep_y[H_LB] = yb;
        prep_x[H_LA] = xl;                     prep_y[H_LA] = ya;
        prep_x[H_RB] = xr;                     prep_y[H_RB] = yb;
        prep_x[H_RA] = xr;                     prep_y[H_RA] = ya;
        prep_x[13]   = x_reg;                  prep_y[13]   = y_reg;
        prep_bad = (x_reg >= len_reg) || (y_reg >= wid_reg);
    end

    // saturating update of the center height
    always_comb begin
        hsum = (HEIGHT_BITS+1)'($signed(rd_a)) + (HEIGHT_BITS+1)'(d_reg);
        if (hsum[HEIGHT_BITS] != hsum[HEIGHT_BITS-1]) begin
            hnew = hsum[HEIGHT_BITS] ? {1'b1, {(HEIGHT_BITS-1){1'b0}}}
                                     : {1'b0, {(HEIGHT_BITS-1){1'b1}}};
        end else begin
            hnew = hsum[HEIGHT_BITS-1:0];
        end
    end

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = (state_reg == ST_READ) && (step_reg == STEP_WRITE);
            ram_waddr = ctr_addr_reg;
            ram_wdata = hnew;
        end
    end

    lhnc_height_ram #(
        .ADDR_BITS (AW),
        .DATA_BITS (HEIGHT_BITS)
    ) u_lhnc_height_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a ({q_x_reg[0][XW-1:0], q_y_reg[0][YW-1:0]}),
        .raddr_b ({q_x_reg[1][XW-1:0], q_y_reg[1][YW-1:0]}),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // entries that alias the center take the updated height
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            h_eff[i] = eq_reg[i] ? hnew_reg : h_line_reg[i];
        end
        c_here  = count_of(h_eff[H_C], h_eff[H_L], h_eff[H_R], h_eff[H_B], h_eff[H_A]);
        c_left  = count_of(h_eff[H_L], h_eff[H_LL], h_eff[H_C], h_eff[H_LB],
                           h_eff[H_LA]);
        c_right = count_of(h_eff[H_R], h_eff[H_C], h_eff[H_RR], h_eff[H_RB],
                           h_eff[H_RA]);
        c_below = count_of(h_eff[H_B], h_eff[H_LB], h_eff[H_RB], h_eff[H_BB],
                           h_eff[H_C]);
        c_above = count_of(h_eff[H_A], h_eff[H_LA], h_eff[H_RA], h_eff[H_C],
                           h_eff[H_AA]);
        h_wide  = 32'(hnew_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == {AW{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = prep_bad ? ST_DONE : ST_READ;
            end
            ST_READ: begin
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            step_reg     <= '0;
            len_reg      <= coord_t'(LEN_RST);
            wid_reg      <= coord_t'(WID_RST);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we) begin
                if (cfg_index == CFG_LENGTH_IN_USE) begin
                    len_reg <= clamp_size(cfg_wdata, coord_t'(LEN_CAP));
                end else begin
                    wid_reg <= clamp_size(cfg_wdata, coord_t'(WID_CAP));
                end
            end
            if (state_reg == ST_PREP) begin
                step_reg <= '0;
            end else if (state_reg == ST_READ) begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x_reg <= coord_t'(s_tdata[POS_BITS-1:0]);
            y_reg <= coord_t'(s_tdata[2*POS_BITS-1:POS_BITS]);
            d_reg <= s_tdata[2*POS_BITS+DELTA_BITS-1:2*POS_BITS];
        end
        if (state_reg == ST_PREP) begin
            bad_reg      <= prep_bad;
            ctr_addr_reg <= {x_reg[XW-1:0], y_reg[YW-1:0]};
            for (int i = 0; i < QLEN; i++) begin
                q_x_reg[i] <= prep_x[i];
                q_y_reg[i] <= prep_y[i];
            end
            for (int i = 0; i < SLOTS; i++) begin
                eq_reg[i] <= (prep_x[i] == x_reg) && (prep_y[i] == y_reg);
            end
        end
        if (state_reg == ST_READ) begin
            for (int i = 0; i < QLEN - 2; i++) begin
                q_x_reg[i] <= q_x_reg[i+2];
                q_y_reg[i] <= q_y_reg[i+2];
            end
            if (step_reg != '0) begin
                for (int i = 0; i < QLEN - 2; i++) begin
                    h_line_reg[i] <= h_line_reg[i+2];
                end
                h_line_reg[QLEN-2] <= rd_a;
                h_line_reg[QLEN-1] <= rd_b;
            end
            if (step_reg == STEP_WRITE) begin
                hnew_reg <= hnew;
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            if (bad_reg) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 1'b1;
            end else begin
                m_tdata_reg <= {1'b0, c_above, c_below, c_right, c_left, c_here,
                                h_wide[OUT_HEIGHT_BITS-1:0]};
                m_tuser_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/lhnc_checker.sv
// ----------------------------------------------------------------------------
// lhnc_checker
// Port-level checks of the lattice block, bound to its top level.
// ----------------------------------------------------------------------------
`include "lattice_height_neighbor_count_macros.svh"

module lhnc_checker
    import lhnc_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata,
    input logic [M_TUSER_BITS-1:0] m_tuser
);

    logic   out_stall;
    count_t here_count;
    logic   count_ok;

    assign out_stall  = m_tvalid && !m_tready;
    assign here_count = m_tdata[OUT_HEIGHT_BITS +: COUNT_BITS];
    assign count_ok   = (here_count >= count_t'(1)) && (here_count <= count_t'(5));

    `LHNC_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid)
    `LHNC_ASSERT_NEXT(a_out_stable, aclk, aresetn, out_stall, $stable(m_tdata) && $stable(m_tuser))
    `LHNC_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `LHNC_ASSERT_SAME(a_bad_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == '0)
    `LHNC_ASSERT_SAME(a_count_range, aclk, aresetn, m_tvalid && !m_tuser[0], count_ok)

endmodule

bind lattice_height_neighbor_count lhnc_checker u_lhnc_checker (.*);

### sim/lhnc_update_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lhnc_update_checker
// Watches the site-update and result streams of the lattice block. It keeps
// its own copy of the lattice heights and of the size registers, predicts each
// result when the site update is taken, and compares results in order.
// ----------------------------------------------------------------------------
module lhnc_update_checker
    import lhnc_pkg::*;
#(
    parameter int MAX_LENGTH = 64,
    parameter int MAX_WIDTH  = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    // [5:0] pos_x, [11:6] pos_y, [19:12] delta, [23:20] zero
    input  logic [S_TDATA_BITS-1:0]   s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // [15:0] new_height, [18:16] count_here, [21:19] count_left,
    // [24:22] count_right, [27:25] count_below, [30:28] count_above, [31] zero
    input  logic [M_TDATA_BITS-1:0]   m_tdata,
    // [0] bad_site
    input  logic [M_TUSER_BITS-1:0]   m_tuser,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    output int                        mismatch_count,
    output int                        updates_pending,
    output int                        updates_checked
);

    localparam int HEIGHT_MAX = (1 << (OUT_HEIGHT_BITS - 1)) - 1;
    localparam int HEIGHT_MIN = -HEIGHT_MAX - 1;

    typedef struct packed {
        logic [OUT_HEIGHT_BITS-1:0] height;
        count_t                     here;
        count_t                     left;
        count_t                     right;
        count_t                     below;
        count_t                     above;
        logic                       bad_site;
    } site_update_t;

    logic signed [OUT_HEIGHT_BITS-1:0] lattice_height [MAX_LENGTH*MAX_WIDTH];
    logic [SIZE_BITS-1:0]              length_reg;
    logic [SIZE_BITS-1:0]              width_reg;
    site_update_t                      expected_updates [$];
    site_update_t                      got;
    site_update_t                      want;
    int                                mismatches = 0;
    int                                checked = 0;

    // zero acts as one, anything above the array size acts as the array size
    function automatic int period(input logic [SIZE_BITS-1:0] v, input int limit);
        if (v == '0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    function automatic count_t site_count(input int x, input int y, input int len,
                                          input int wid);
        int h;
        int n;
        h = lattice_height[x*MAX_WIDTH + y];
        n = 1;
        if (int'(lattice_height[((x + len - 1) % len)*MAX_WIDTH + y]) >= h) n++;
        if (int'(lattice_height[((x + 1) % len)*MAX_WIDTH + y]) >= h) n++;
        if (int'(lattice_height[x*MAX_WIDTH + (y + wid - 1) % wid]) >= h) n++;
        if (int'(lattice_height[x*MAX_WIDTH + (y + 1) % wid]) >= h) n++;
        return count_t'(n);
    endfunction

    // updates the local lattice and returns the result the block owes
    function automatic site_update_t apply_site_update(input logic [S_TDATA_BITS-1:0] word);
        int                            x;
        int                            y;
        int                            len;
        int                            wid;
        int                            sum;
        int                            xl;
        int                            xr;
        int                            yb;
        int                            ya;
        logic signed [DELTA_BITS-1:0]  delta;
        site_update_t                  r;
        x     = int'(word[POS_BITS-1:0]);
        y     = int'(word[2*POS_BITS-1:POS_BITS]);
        delta = word[2*POS_BITS +: DELTA_BITS];
        len   = period(length_reg, MAX_LENGTH);
        wid   = period(width_reg, MAX_WIDTH);
        r     = '0;
        if (x >= len || y >= wid) begin
            r.bad_site = 1'b1;
            return r;
        end
        sum = int'(lattice_height[x*MAX_WIDTH + y]) + int'(delta);
        if (sum > HEIGHT_MAX) sum = HEIGHT_MAX;
        if (sum < HEIGHT_MIN) sum = HEIGHT_MIN;
        lattice_height[x*MAX_WIDTH + y] = sum[OUT_HEIGHT_BITS-1:0];
        xl = (x + len - 1) % len;
        xr = (x + 1) % len;
        yb = (y + wid - 1) % wid;
        ya = (y + 1) % wid;
        r.height = sum[OUT_HEIGHT_BITS-1:0];
        r.here   = site_count(x, y, len, wid);
        r.left   = site_count(xl, y, len, wid);
        r.right  = site_count(xr, y, len, wid);
        r.below  = site_count(x, yb, len, wid);
        r.above  = site_count(x, ya, len, wid);
        return r;
    endfunction

    task automatic compare_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, actual %0d", field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (lattice_height[i]) lattice_height[i] = '0;
            length_reg = SIZE_BITS'(MAX_LENGTH);
            width_reg  = SIZE_BITS'(MAX_WIDTH);
            expected_updates.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LENGTH_IN_USE: length_reg = cfg_wdata;
                    CFG_WIDTH_IN_USE:  width_reg  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.height   = m_tdata[OUT_HEIGHT_BITS-1:0];
                got.here     = m_tdata[OUT_HEIGHT_BITS + 0*COUNT_BITS +: COUNT_BITS];
                got.left     = m_tdata[OUT_HEIGHT_BITS + 1*COUNT_BITS +: COUNT_BITS];
                got.right    = m_tdata[OUT_HEIGHT_BITS + 2*COUNT_BITS +: COUNT_BITS];
                got.below    = m_tdata[OUT_HEIGHT_BITS + 3*COUNT_BITS +: COUNT_BITS];
                got.above    = m_tdata[OUT_HEIGHT_BITS + 4*COUNT_BITS +: COUNT_BITS];
                got.bad_site = m_tuser[0];
                if (expected_updates.size() == 0) begin
                    $error("result transfer with no site update outstanding");
                    mismatches++;
                end else begin
                    want = expected_updates.pop_front();
                    compare_field("new_height", int'(signed'(want.height)),
                                  int'(signed'(got.height)));
                    compare_field("count_here", want.here, got.here);
                    compare_field("count_left", want.left, got.left);
                    compare_field("count_right", want.right, got.right);
                    compare_field("count_below", want.below, got.below);
                    compare_field("count_above", want.above, got.above);
                    compare_field("bad_site", want.bad_site, got.bad_site);
                    checked++;
                end
            end
            if (s_tvalid && s_tready) expected_updates.push_back(apply_site_update(s_tdata));
        end
        mismatch_count  <= mismatches;
        updates_pending <= expected_updates.size();
        updates_checked <= checked;
    end

endmodule

### sim/tb_lattice_height_neighbor_count.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lattice_height_neighbor_count
// Drives site updates into the lattice block across a series of lattice
// sizes, with bursty input and a stalling receiver; the update checker
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module tb_lattice_height_neighbor_count;
    import lhnc_pkg::*;

    localparam int  LIMIT_CYCLES  = 400000;
    localparam int  LATTICE_SPAN  = 64;
    localparam logic [7:0] STALL_PATTERN = 8'b1011_0010;

    typedef enum {MIX_SITES, CLIMB_SITES, TIE_SITES} phase_style_t;
    typedef enum {READY_ALWAYS, READY_COIN, READY_RARE, READY_PATTERN} ready_mode_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic [M_TUSER_BITS-1:0]   m_tuser;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    int          fails;
    int          pending;
    int          checked;
    int          burst_left = 0;
    int          items_sent = 0;
    int          size_settings = 0;
    int          cycle_count = 0;
    int          ready_tick = 0;
    ready_mode_t ready_mode = READY_ALWAYS;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    lattice_height_neighbor_count dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lhnc_update_checker u_update_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (fails),
        .updates_pending (pending),
        .updates_checked (checked)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver periodically picks a new stall behavior at random
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 128 == 0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
        case (ready_mode)
            READY_ALWAYS: m_tready <= 1'b1;
            READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            READY_RARE:   m_tready <= ($urandom_range(0, 4) == 0);
            default:      m_tready <= STALL_PATTERN[ready_tick % 8];
        endcase
    end

    task automatic send_site(input int x, input int y, input int d);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
            burst_left--;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'({DELTA_BITS'(d), POS_BITS'(y), POS_BITS'(x)});
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic finish_phase();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_sizes(input int len_v, input int wid_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LENGTH_IN_USE;
        cfg_wdata <= CFG_DATA_BITS'(len_v);
        @(posedge aclk);
        cfg_index <= CFG_WIDTH_IN_USE;
        cfg_wdata <= CFG_DATA_BITS'(wid_v);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        size_settings++;
    endtask

    // mostly inside the lattice in use, sometimes anywhere the field allows
    function automatic int pick_coord(input int span);
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, span - 1);
        return $urandom_range(0, LATTICE_SPAN - 1);
    endfunction

    task automatic run_phase(input int len_v, input int wid_v, input int span_x,
                             input int span_y, input int count, input phase_style_t how);
        int x;
        int y;
        int d;
        write_sizes(len_v, wid_v);
        for (int i = 0; i < count; i++) begin
            x = pick_coord(span_x);
            y = pick_coord(span_y);
            case (how)
                CLIMB_SITES: begin
                    // two sites driven toward opposite saturation limits
                    if (i % 25 == 24) begin
                        x = $urandom_range(0, LATTICE_SPAN - 1);
                        y = $urandom_range(0, LATTICE_SPAN - 1);
                        d = $urandom_range(0, 255);
                    end else if (i % 2 == 0) begin
                        x = 0;
                        y = 0;
                        d = $urandom_range(122, 127);
                    end else begin
                        x = 1;
                        y = 0;
                        d = 0 - int'($urandom_range(122, 128));
                    end
                end
                TIE_SITES: d = int'($urandom_range(0, 6)) - 3;
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        case ($urandom_range(0, 4))
                            0:       d = -128;
                            1:       d = 127;
                            2:       d = 0;
                            3:       d = -1;
                            default: d = 1;
                        endcase
                    end else begin
                        d = $urandom_range(0, 255);
                    end
                end
            endcase
            send_site(x, y, d);
        end
        finish_phase();
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_LENGTH_IN_USE;
        cfg_wdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // full 64 x 64 lattice at reset sizes: corners, wrap and field extremes
        send_site(0, 0, 127);
        send_site(0, 0, -128);
        send_site(0, 0, 0);
        send_site(63, 63, 127);
        send_site(63, 0, -1);
        send_site(0, 63, 1);
        send_site(1, 0, -128);
        send_site(63, 63, -128);
        send_site(0, 1, 5);
        // plus-shaped group with equal heights, then a raised and a sunk center
        send_site(31, 32, 3);
        send_site(33, 32, 3);
        send_site(32, 31, 3);
        send_site(32, 33, 3);
        send_site(32, 32, 3);
        send_site(32, 32, 1);
        send_site(32, 32, -2);
        send_site(32, 32, 1);
        send_site(17, 42, -128);
        send_site(17, 42, -128);
        send_site(17, 42, -128);
        send_site(42, 17, 127);
        send_site(42, 17, 127);
        send_site(62, 63, 0);
        finish_phase();

        run_phase(2, 1, 2, 1, 600, CLIMB_SITES);
        run_phase(1, 1, 1, 1, 20, MIX_SITES);
        run_phase(0, 127, 1, 64, 30, MIX_SITES);
        run_phase(127, 0, 64, 1, 30, MIX_SITES);
        run_phase(3, 5, 3, 5, 45, TIE_SITES);
        run_phase(2, 2, 2, 2, 30, TIE_SITES);
        run_phase(64, 64, 4, 4, 35, TIE_SITES);
        run_phase(5, 3, 5, 3, 30, MIX_SITES);

        repeat (16) @(posedge aclk);
        $display("%0d site updates over %0d lattice size settings, %0d results compared",
                 items_sent, size_settings + 1, checked);
        $display("sizes from 1 x 1 to 64 x 64 incl. out-of-range writes, saturation, off-lattice");
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
